// ----- hdl/dlefr_pkg.sv -----
`default_nettype none

package dlefr_pkg;

    // Framing bytes, inversion mask and checksum target
    localparam logic [7:0] END_BYTE    = 8'h03;
    localparam logic [7:0] ESC_BYTE    = 8'h10;
    localparam logic [7:0] INVERT_MASK = 8'hFF;
    localparam logic [7:0] SUM_TARGET  = 8'h55;

    typedef enum logic [0:0] {
        KIND_DATA   = 1'b0,
        KIND_REPORT = 1'b1
    } word_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_SHORT    = 2'd1,
        ERR_OVERFLOW = 2'd2,
        ERR_TOO_LONG = 2'd3
    } frame_err_t;

    typedef struct packed {
        word_kind_t  kind;
        logic [7:0]  data_byte;
        logic        frame_done;
        logic        checksum_ok;
        logic [15:0] frame_length;
        frame_err_t  frame_error;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/dle_frame_receiver_checksum_top.sv -----
`default_nettype none

// DLE frame receiver with additive checksum. Raw serial bytes enter on the
// in_valid/in_ready channel, one word per handshake; decoded data bytes and
// one end-of-frame report per frame leave on out_valid/out_ready. The first
// raw byte of a frame is the start marker and is dropped, 0x10 escapes the
// next byte (which is inverted), and 0x03 ends the frame at any point. The
// first two decoded bytes give the length L (low byte first); the report
// flags checksum_ok when the 8-bit sum of decoded bytes 0..L+1 is 0x55 and
// no error was seen. Errors by priority: raw overflow (more than RAW_DEPTH
// raw bytes, excess dropped), length too large (L >= LENGTH_LIMIT), too
// short (fewer than L+2 decoded bytes). Throughput is one word per clock
// while out_ready keeps up: a byte is captured in an input register,
// decoded by a compare, an optional inversion and an 8-bit add, and lands
// in the output register once that can take it. Words that give no result
// (start marker, escape, dropped overflow byte) still pass the pipe.
// in_ready falls only while out_ready leaves a word in the output register.
module dle_frame_receiver_checksum_top #(
    parameter int RAW_DEPTH    = 128,
    parameter int LENGTH_LIMIT = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             kind,
    output logic [7:0]       data_byte,
    output logic             frame_done,
    output logic             checksum_ok,
    output logic [15:0]      frame_length,
    output logic [1:0]       frame_error
);
    import dlefr_pkg::*;

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    logic       advance;
    logic       can_load;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    // Advance the captured byte whenever the output register can take its result.
    assign advance  = in_valid_reg && can_load;
    assign in_ready = !in_valid_reg || can_load;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
            in_valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // Hold the byte until it advances.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= rx_byte;
    end

    dlefr_decode #(
        .RAW_DEPTH    (RAW_DEPTH),
        .LENGTH_LIMIT (LENGTH_LIMIT)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .byte_in   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    dlefr_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .can_load  (can_load),
        .out_res   (out_res)
    );

    assign kind         = out_res.kind;
    assign data_byte    = out_res.data_byte;
    assign frame_done   = out_res.frame_done;
    assign checksum_ok  = out_res.checksum_ok;
    assign frame_length = out_res.frame_length;
    assign frame_error  = out_res.frame_error;

endmodule

`default_nettype wire

// ----- hdl/dlefr_decode.sv -----
`default_nettype none

module dlefr_decode #(
    parameter int RAW_DEPTH    = 128,
    parameter int LENGTH_LIMIT = 256
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic [7:0]       byte_in,
    output logic                  res_valid,
    output dlefr_pkg::result_t    res
);
    import dlefr_pkg::*;

    logic [7:0]  raw_count_reg,      raw_count_next;
    logic        escape_pending_reg, escape_pending_next;
    logic [7:0]  decoded_count_reg,  decoded_count_next;
    logic [15:0] length_field_reg,   length_field_next;
    logic [7:0]  running_sum_reg,    running_sum_next;
    logic        overflow_seen_reg,  overflow_seen_next;

    logic [7:0]  dec_byte;
    logic        emit;
    logic [16:0] len_plus_one;
    logic [16:0] len_plus_two;
    frame_err_t  err;

    always_comb
    begin
        raw_count_next      = raw_count_reg;
        escape_pending_next = escape_pending_reg;
        decoded_count_next  = decoded_count_reg;
        length_field_next   = length_field_reg;
        running_sum_next    = running_sum_reg;
        overflow_seen_next  = overflow_seen_reg;
        dec_byte            = byte_in;
        emit                = 1'b0;
        err                 = ERR_NONE;
        len_plus_one        = {1'b0, length_field_reg} + 17'd1;
        len_plus_two        = {1'b0, length_field_reg} + 17'd2;

        res              = '0;
        res.kind         = KIND_DATA;
        res.frame_error  = ERR_NONE;
        res_valid        = 1'b0;

        if (byte_in == END_BYTE)
        begin
            if (overflow_seen_reg)
                err = ERR_OVERFLOW;
            else if ({1'b0, length_field_reg} >= 17'(LENGTH_LIMIT))
                err = ERR_TOO_LONG;
            else if ({9'd0, decoded_count_reg} < len_plus_two)
                err = ERR_SHORT;
            res_valid        = 1'b1;
            res.kind         = KIND_REPORT;
            res.frame_done   = 1'b1;
            res.checksum_ok  = (err == ERR_NONE) && (running_sum_reg == SUM_TARGET);
            res.frame_length = length_field_reg;
            res.frame_error  = err;
            raw_count_next      = '0;
            escape_pending_next = 1'b0;
            decoded_count_next  = '0;
            length_field_next   = '0;
            running_sum_next    = '0;
            overflow_seen_next  = 1'b0;
        end
        else if (raw_count_reg >= 8'(RAW_DEPTH))
        begin
            overflow_seen_next = 1'b1;
        end
        else
        begin
            raw_count_next = raw_count_reg + 8'd1;
            if (raw_count_reg == 8'd0)
            begin
                // start marker: drop
            end
            else if (escape_pending_reg)
            begin
                escape_pending_next = 1'b0;
                dec_byte            = byte_in ^ INVERT_MASK;
                emit                = 1'b1;
            end
            else if (byte_in == ESC_BYTE)
            begin
                escape_pending_next = 1'b1;
            end
            else
            begin
                emit = 1'b1;
            end
        end

        if (emit)
        begin
            if (decoded_count_reg == 8'd0)
                length_field_next = {length_field_reg[15:8], dec_byte};
            else if (decoded_count_reg == 8'd1)
                length_field_next = {dec_byte, length_field_reg[7:0]};
            len_plus_one = {1'b0, length_field_next} + 17'd1;
            if ({9'd0, decoded_count_reg} <= len_plus_one)
                running_sum_next = running_sum_reg + dec_byte;
            if (decoded_count_reg != 8'hFF)
                decoded_count_next = decoded_count_reg + 8'd1;
            res_valid     = 1'b1;
            res.data_byte = dec_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_count_reg      <= '0;
            escape_pending_reg <= 1'b0;
            decoded_count_reg  <= '0;
            length_field_reg   <= '0;
            running_sum_reg    <= '0;
            overflow_seen_reg  <= 1'b0;
        end
        else if (advance)
        begin
            raw_count_reg      <= raw_count_next;
            escape_pending_reg <= escape_pending_next;
            decoded_count_reg  <= decoded_count_next;
            length_field_reg   <= length_field_next;
            running_sum_reg    <= running_sum_next;
            overflow_seen_reg  <= overflow_seen_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dlefr_out_reg.sv -----
`default_nettype none

module dlefr_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire logic             res_valid,
    input  wire dlefr_pkg::result_t res,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output logic                  can_load,
    output dlefr_pkg::result_t    out_res
);
    import dlefr_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    // The register may take a new word when empty or when its word leaves now.
    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = res_valid;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

// ----- bench/dlefr_frame_checker.sv -----
module dlefr_frame_checker #(
    parameter int RAW_DEPTH    = 128,
    parameter int LENGTH_LIMIT = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic        kind,
    input  wire logic [7:0]  data_byte,
    input  wire logic        frame_done,
    input  wire logic        checksum_ok,
    input  wire logic [15:0] frame_length,
    input  wire logic [1:0]  frame_error,
    output int               fail_count,
    output int               words_pending
);
    import dlefr_pkg::*;

    // Shadow of the receiver's frame state
    logic [7:0]  raw_seen;
    logic        esc_armed;
    logic [7:0]  decoded_seen;
    logic [15:0] len_field;
    logic [7:0]  byte_sum;
    logic        dropped_raw;

    result_t     outbound[$];
    int          mismatches = 0;
    int          words_seen = 0;
    int          backlog = 0;

    assign fail_count    = mismatches;
    assign words_pending = backlog;

    function automatic void clear_frame();
        raw_seen     = '0;
        esc_armed    = 1'b0;
        decoded_seen = '0;
        len_field    = '0;
        byte_sum     = '0;
        dropped_raw  = 1'b0;
    endfunction

    // Advance the shadow state by one raw byte; return 1 when it yields a word.
    function automatic bit decode_rx_byte(input logic [7:0] b, output result_t w);
        logic [7:0] d;
        frame_err_t err;
        w = '0;
        if (b == END_BYTE) begin
            if (dropped_raw)
                err = ERR_OVERFLOW;
            else if (int'(len_field) >= LENGTH_LIMIT)
                err = ERR_TOO_LONG;
            else if (int'(decoded_seen) < int'(len_field) + 2)
                err = ERR_SHORT;
            else
                err = ERR_NONE;
            w.kind         = KIND_REPORT;
            w.frame_done   = 1'b1;
            w.checksum_ok  = (err == ERR_NONE) && (byte_sum == SUM_TARGET);
            w.frame_length = len_field;
            w.frame_error  = err;
            clear_frame();
            return 1'b1;
        end
        if (int'(raw_seen) >= RAW_DEPTH) begin
            dropped_raw = 1'b1;
            return 1'b0;
        end
        raw_seen = raw_seen + 8'd1;
        if (raw_seen == 8'd1)
            return 1'b0;
        if (esc_armed) begin
            esc_armed = 1'b0;
            d = b ^ INVERT_MASK;
        end
        else if (b == ESC_BYTE) begin
            esc_armed = 1'b1;
            return 1'b0;
        end
        else begin
            d = b;
        end
        if (decoded_seen == 8'd0)
            len_field[7:0] = d;
        else if (decoded_seen == 8'd1)
            len_field[15:8] = d;
        if (int'(decoded_seen) <= int'(len_field) + 1)
            byte_sum = byte_sum + d;
        if (decoded_seen != 8'd255)
            decoded_seen = decoded_seen + 8'd1;
        w.kind      = KIND_DATA;
        w.data_byte = d;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        $display("ERROR word %0d: %s got %0h want %0h", words_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t w;
        bit      made;
        if (!rst_n) begin
            clear_frame();
            outbound.delete();
            backlog <= 0;
        end
        else begin
            if (in_valid && in_ready) begin
                made = decode_rx_byte(rx_byte, w);
                if (made)
                    outbound.push_back(w);
            end
            if (out_valid && out_ready) begin
                if (outbound.size() == 0) begin
                    flag_mismatch("word with nothing pending", 16'({kind, data_byte}),
                                  16'd0);
                end
                else begin
                    w = outbound.pop_front();
                    if (kind !== w.kind)
                        flag_mismatch("kind", 16'(kind), 16'(w.kind));
                    if (data_byte !== w.data_byte)
                        flag_mismatch("data_byte", 16'(data_byte), 16'(w.data_byte));
                    if (frame_done !== w.frame_done)
                        flag_mismatch("frame_done", 16'(frame_done), 16'(w.frame_done));
                    if (checksum_ok !== w.checksum_ok)
                        flag_mismatch("checksum_ok", 16'(checksum_ok), 16'(w.checksum_ok));
                    if (frame_length !== w.frame_length)
                        flag_mismatch("frame_length", frame_length, w.frame_length);
                    if (frame_error !== w.frame_error)
                        flag_mismatch("frame_error", 16'(frame_error), 16'(w.frame_error));
                end
                words_seen++;
            end
            backlog <= outbound.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
module testbench;
    import dlefr_pkg::*;

    localparam int RAW_DEPTH    = 128;
    localparam int LENGTH_LIMIT = 256;
    localparam int RAND_BYTES   = 1600;

    // How a generated frame departs from a well-formed one
    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_SHORT,
        FRAME_PADDED,
        FRAME_DANGLING,
        FRAME_NOISE
    } frame_shape_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic        frame_done;
    logic        checksum_ok;
    logic [15:0] frame_length;
    logic [1:0]  frame_error;

    int          fail_count;
    int          words_pending;
    int          bytes_sent = 0;
    int          stall_left = 0;
    // While set, neither side inserts gaps: back-to-back words
    logic        quiet = 1'b0;

    dle_frame_receiver_checksum_top #(
        .RAW_DEPTH    (RAW_DEPTH),
        .LENGTH_LIMIT (LENGTH_LIMIT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .data_byte    (data_byte),
        .frame_done   (frame_done),
        .checksum_ok  (checksum_ok),
        .frame_length (frame_length),
        .frame_error  (frame_error)
    );

    dlefr_frame_checker #(
        .RAW_DEPTH    (RAW_DEPTH),
        .LENGTH_LIMIT (LENGTH_LIMIT)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .data_byte     (data_byte),
        .frame_done    (frame_done),
        .checksum_ok   (checksum_ok),
        .frame_length  (frame_length),
        .frame_error   (frame_error),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Payload byte biased toward the framing bytes so escapes show up often.
    function automatic logic [7:0] pick_data();
        if ($urandom_range(0, 99) < 15)
            return $urandom_range(0, 1) ? END_BYTE : ESC_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Receiver side: drop out_ready for random stretches, hold it otherwise.
    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= 1'b1;
        end
    end

    // Present one raw byte and hold it until the word is taken. With no gap
    // the valid stays high straight into the next word.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    // Build one frame: start marker, length low/high, payload, checksum byte,
    // stuffed as needed, then the end byte. The shape bends it out of form.
    task automatic send_frame(input logic [15:0] len, input frame_shape_t shape);
        logic [7:0] body[$];
        logic [7:0] sum;
        logic [7:0] b;
        int         cut;
        int         i;
        if (shape == FRAME_NOISE) begin
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
            send_byte(END_BYTE);
            return;
        end
        body.push_back(len[7:0]);
        body.push_back(len[15:8]);
        if (int'(len) < LENGTH_LIMIT) begin
            for (i = 0; i < int'(len); i++)
                body.push_back(pick_data());
        end
        else begin
            repeat ($urandom_range(0, 6)) body.push_back(pick_data());
        end
        sum = '0;
        for (i = 0; i < body.size(); i++)
            sum = sum + body[i];
        body.push_back(8'(SUM_TARGET - sum));
        case (shape)
            FRAME_BAD_SUM: body[body.size() - 1] ^= 8'($urandom_range(1, 255));
            FRAME_SHORT: begin
                cut = $urandom_range(0, body.size() - 1);
                while (body.size() > cut)
                    void'(body.pop_back());
            end
            FRAME_PADDED: repeat ($urandom_range(1, 4)) body.push_back(pick_data());
            default: ;
        endcase
        // Any start marker but the end byte; an escape here is simply dropped.
        do
            b = 8'($urandom_range(0, 255));
        while (b == END_BYTE);
        send_byte(b);
        // Stuff the framing bytes, and now and then an ordinary one, but never
        // a byte whose inverse would read as the end byte.
        for (i = 0; i < body.size(); i++) begin
            if (body[i] == END_BYTE || body[i] == ESC_BYTE ||
                (body[i] != (END_BYTE ^ INVERT_MASK) && $urandom_range(0, 19) == 0)) begin
                send_byte(ESC_BYTE);
                send_byte(body[i] ^ INVERT_MASK);
            end
            else begin
                send_byte(body[i]);
            end
        end
        if (shape == FRAME_DANGLING)
            send_byte(ESC_BYTE);
        send_byte(END_BYTE);
    endtask

    initial
    begin
        logic [15:0]  len;
        frame_shape_t shape;
        int           r;
        int           start_count;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        out_ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // End byte as the very first byte: empty frame, flagged short.
        send_byte(END_BYTE);
        // Minimal good frame, L = 1, sum 01 + 00 + 54 = 55.
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h54);
        send_byte(END_BYTE);
        // Escape as start marker, then an escaped escape past the summed range.
        send_byte(ESC_BYTE);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(ESC_BYTE);
        send_byte(ESC_BYTE);
        send_byte(END_BYTE);
        // Length exactly at the limit.
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(END_BYTE);
        // Escaped end byte decodes to 03, then a dangling escape at the end.
        send_byte(8'hAA);
        send_byte(ESC_BYTE);
        send_byte(END_BYTE ^ INVERT_MASK);
        send_byte(ESC_BYTE);
        send_byte(END_BYTE);

        // Random frames: mostly well formed with random content, some broken.
        start_count = bytes_sent;
        while (bytes_sent < start_count + RAND_BYTES) begin
            quiet <= ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            if (r < 70)
                len = 16'($urandom_range(0, 12));
            else if (r < 85)
                len = 16'($urandom_range(13, 60));
            else if (r < 93)
                len = 16'($urandom_range(100, 140));
            else if (r < 97)
                len = 16'($urandom_range(LENGTH_LIMIT, 65535));
            else
                len = 16'(LENGTH_LIMIT - 1);
            r = $urandom_range(0, 99);
            if (r < 60)
                shape = FRAME_GOOD;
            else if (r < 70)
                shape = FRAME_BAD_SUM;
            else if (r < 80)
                shape = FRAME_SHORT;
            else if (r < 88)
                shape = FRAME_PADDED;
            else if (r < 94)
                shape = FRAME_DANGLING;
            else
                shape = FRAME_NOISE;
            send_frame(len, shape);
        end
        in_valid <= 1'b0;
        quiet    <= 1'b0;

        // Drain: wait for every pending word, then a few cycles for stragglers.
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hang guard: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/dlefr_pkg.sv
hdl/dlefr_decode.sv
hdl/dlefr_out_reg.sv
hdl/dle_frame_receiver_checksum_top.sv
bench/dlefr_frame_checker.sv
bench/testbench.sv
